// ===== rtl/core/irr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the IP range reputation table.
// No dependencies; used by every other file of the block but irr_if.
package irr_pkg;

   localparam int V4_DEPTH    = 1024;
   localparam int V6_DEPTH    = 256;
   localparam int LABEL_COUNT = 256;

   localparam int WALK_W = $clog2((V4_DEPTH > V6_DEPTH) ? V4_DEPTH : V6_DEPTH);

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_CLEAR  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_REVERSED = 2'd2
   } status_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] start;
      logic [31:0] stop;
      logic        src;
      logic [7:0]  lab;
   } v4_entry_type;

   typedef struct packed {
      logic         valid;
      logic [127:0] start;
      logic [127:0] stop;
      logic         src;
      logic [7:0]   lab;
   } v6_entry_type;

   // broadcast to every cell of a row
   typedef struct packed {
      logic        ins;
      logic        look;
      logic        walk;
      logic        clr;
      logic [31:0] key;
      logic [31:0] stop;
      logic        src;
      logic [7:0]  lab;
   } v4_ctl_type;

   typedef struct packed {
      logic         ins;
      logic         look;
      logic         walk;
      logic         clr;
      logic [127:0] key;
      logic [127:0] stop;
      logic         src;
      logic [7:0]   lab;
   } v6_ctl_type;

   // lookup result travelling down a row
   typedef struct packed {
      logic       hit;
      logic       src;
      logic [7:0] lab;
   } acc_type;

   function automatic logic [7:0] sat_label(input logic [7:0] lab);
      logic [7:0] res;
      res = lab;
      if (32'(lab) >= 32'(LABEL_COUNT)) begin
         res = 8'(LABEL_COUNT - 1);
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/irr_if.sv =====
`timescale 1ns / 1ps
// Request and response channel interfaces of the IP range reputation table.
// Depends on nothing; follows irr_pkg in compile order.
interface irr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic        family;
   logic [63:0] addr_hi;
   logic [63:0] addr_lo;
   logic [63:0] end_hi;
   logic [63:0] end_lo;
   logic        source_id;
   logic [7:0]  label_id;

   modport source (output valid, command, family, addr_hi, addr_lo, end_hi, end_lo,
                   source_id, label_id, input ready);
   modport sink (input valid, command, family, addr_hi, addr_lo, end_hi, end_lo,
                 source_id, label_id, output ready);
endinterface

interface irr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        hit;
   logic        hit_source;
   logic [7:0]  hit_label;
   logic [10:0] v4_entries;
   logic [8:0]  v6_entries;
   logic [10:0] blocklist_entries;
   logic [10:0] exitlist_entries;

   modport source (output valid, status, hit, hit_source, hit_label, v4_entries,
                   v6_entries, blocklist_entries, exitlist_entries, input ready);
   modport sink (input valid, status, hit, hit_source, hit_label, v4_entries,
                 v6_entries, blocklist_entries, exitlist_entries, output ready);
endinterface

// ===== rtl/core/ip_range_reputation_table.sv =====
`timescale 1ns / 1ps
// Top level of the IP range reputation table: two rows of sorted cells and
// the request sequencer. Uses irr_pkg, irr_if, irr_v4_cell, irr_v6_cell.
//
//   channel  dir  handshake      payload
//   req_bus  in   valid/ready    command family addr_hi/lo end_hi/lo source_id label_id
//   rsp_bus  out  valid/ready    status hit hit_source hit_label and four counts
//
// Insert, clear and unknown commands: accept moves the sequencer to S_DONE, which
// registers the response and returns to S_IDLE, where the next request is taken.
// Lookup: the sequencer stays in S_WALK while the result chain moves one cell per
// cycle along the whole row (1024 IPv4, 256 IPv6 cells), then goes to S_DONE.
// One request in flight; a new request is taken while the previous response
// still waits on rsp_bus, and its own response holds until that one is taken.
// Reset empties both rows at once, no clearing pass.
module ip_range_reputation_table (
   input logic       clock,
   input logic       reset,
   irr_req_if.sink   req_bus,
   irr_rsp_if.source rsp_bus
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_DONE
   } state_type;

   state_type                     state_ff;
   logic [irr_pkg::WALK_W-1:0]    walk_ff;
   logic [irr_pkg::WALK_W-1:0]    walk_last;
   logic                          look_ff;
   logic                          fam_ff;
   logic [1:0]                    status_ff;
   logic [1:0]                    status_in;
   logic [10:0]                   v4_cnt_ff;
   logic [8:0]                    v6_cnt_ff;
   logic [10:0]                   bl_cnt_ff;
   logic [10:0]                   ex_cnt_ff;
   logic                          rsp_valid_ff;
   logic [1:0]                    rsp_status_ff;
   irr_pkg::acc_type              rsp_acc_ff;
   logic [10:0]                   rsp_v4_ff;
   logic [8:0]                    rsp_v6_ff;
   logic [10:0]                   rsp_bl_ff;
   logic [10:0]                   rsp_ex_ff;
   irr_pkg::acc_type              res_acc;
   logic                          accept;
   logic                          is_insert;
   logic                          reversed;
   logic                          full;
   logic                          ins_ok;
   logic [7:0]                    lab_sat;

   irr_pkg::v4_ctl_type   v4_ctl;
   irr_pkg::v6_ctl_type   v6_ctl;
   irr_pkg::v4_entry_type v4_ent [irr_pkg::V4_DEPTH];
   logic                  v4_gt  [irr_pkg::V4_DEPTH];
   irr_pkg::acc_type      v4_acc [irr_pkg::V4_DEPTH];
   irr_pkg::v6_entry_type v6_ent [irr_pkg::V6_DEPTH];
   logic                  v6_gt  [irr_pkg::V6_DEPTH];
   irr_pkg::acc_type      v6_acc [irr_pkg::V6_DEPTH];

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign is_insert     = (req_bus.command == irr_pkg::CMD_INSERT);
   assign lab_sat       = irr_pkg::sat_label(req_bus.label_id);

   assign reversed = req_bus.family ?
                     ({req_bus.end_hi, req_bus.end_lo} < {req_bus.addr_hi, req_bus.addr_lo}) :
                     (req_bus.end_lo[31:0] < req_bus.addr_lo[31:0]);
   assign full     = req_bus.family ? (32'(v6_cnt_ff) >= 32'(irr_pkg::V6_DEPTH)) :
                                      (32'(v4_cnt_ff) >= 32'(irr_pkg::V4_DEPTH));
   assign ins_ok   = accept && is_insert && !reversed && !full;

   always_comb begin
      status_in = irr_pkg::ST_OK;
      if (is_insert) begin
         if (reversed) begin
            status_in = irr_pkg::ST_REVERSED;
         end else if (full) begin
            status_in = irr_pkg::ST_FULL;
         end
      end
   end

   always_comb begin
      v4_ctl.ins  = ins_ok && !req_bus.family;
      v4_ctl.look = accept && (req_bus.command == irr_pkg::CMD_LOOKUP) && !req_bus.family;
      v4_ctl.walk = (state_ff == S_WALK);
      v4_ctl.clr  = accept && (req_bus.command == irr_pkg::CMD_CLEAR);
      v4_ctl.key  = req_bus.addr_lo[31:0];
      v4_ctl.stop = req_bus.end_lo[31:0];
      v4_ctl.src  = req_bus.source_id;
      v4_ctl.lab  = lab_sat;
      v6_ctl.ins  = ins_ok && req_bus.family;
      v6_ctl.look = accept && (req_bus.command == irr_pkg::CMD_LOOKUP) && req_bus.family;
      v6_ctl.walk = (state_ff == S_WALK);
      v6_ctl.clr  = accept && (req_bus.command == irr_pkg::CMD_CLEAR);
      v6_ctl.key  = {req_bus.addr_hi, req_bus.addr_lo};
      v6_ctl.stop = {req_bus.end_hi, req_bus.end_lo};
      v6_ctl.src  = req_bus.source_id;
      v6_ctl.lab  = lab_sat;
   end

   genvar gi;
   generate
      for (gi = 0; gi < irr_pkg::V4_DEPTH; gi++) begin : g_v4
         if (gi == 0) begin : g_first
            irr_v4_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .ctl        (v4_ctl),
               .prev_entry ('0),
               .prev_gt    (1'b0),
               .next_gt    ((gi == irr_pkg::V4_DEPTH - 1) ? 1'b1 :
                            v4_gt[(gi + 1) % irr_pkg::V4_DEPTH]),
               .prev_acc   ('0),
               .entry      (v4_ent[gi]),
               .gt         (v4_gt[gi]),
               .acc        (v4_acc[gi])
            );
         end else if (gi == irr_pkg::V4_DEPTH - 1) begin : g_last
            irr_v4_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .ctl        (v4_ctl),
               .prev_entry (v4_ent[gi - 1]),
               .prev_gt    (v4_gt[gi - 1]),
               .next_gt    (1'b1),
               .prev_acc   (v4_acc[gi - 1]),
               .entry      (v4_ent[gi]),
               .gt         (v4_gt[gi]),
               .acc        (v4_acc[gi])
            );
         end else begin : g_mid
            irr_v4_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .ctl        (v4_ctl),
               .prev_entry (v4_ent[gi - 1]),
               .prev_gt    (v4_gt[gi - 1]),
               .next_gt    (v4_gt[gi + 1]),
               .prev_acc   (v4_acc[gi - 1]),
               .entry      (v4_ent[gi]),
               .gt         (v4_gt[gi]),
               .acc        (v4_acc[gi])
            );
         end
      end

      for (gi = 0; gi < irr_pkg::V6_DEPTH; gi++) begin : g_v6
         if (gi == 0) begin : g_first
            irr_v6_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .ctl        (v6_ctl),
               .prev_entry ('0),
               .prev_gt    (1'b0),
               .next_gt    ((gi == irr_pkg::V6_DEPTH - 1) ? 1'b1 :
                            v6_gt[(gi + 1) % irr_pkg::V6_DEPTH]),
               .prev_acc   ('0),
               .entry      (v6_ent[gi]),
               .gt         (v6_gt[gi]),
               .acc        (v6_acc[gi])
            );
         end else if (gi == irr_pkg::V6_DEPTH - 1) begin : g_last
            irr_v6_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .ctl        (v6_ctl),
               .prev_entry (v6_ent[gi - 1]),
               .prev_gt    (v6_gt[gi - 1]),
               .next_gt    (1'b1),
               .prev_acc   (v6_acc[gi - 1]),
               .entry      (v6_ent[gi]),
               .gt         (v6_gt[gi]),
               .acc        (v6_acc[gi])
            );
         end else begin : g_mid
            irr_v6_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .ctl        (v6_ctl),
               .prev_entry (v6_ent[gi - 1]),
               .prev_gt    (v6_gt[gi - 1]),
               .next_gt    (v6_gt[gi + 1]),
               .prev_acc   (v6_acc[gi - 1]),
               .entry      (v6_ent[gi]),
               .gt         (v6_gt[gi]),
               .acc        (v6_acc[gi])
            );
         end
      end
   endgenerate

   assign walk_last = fam_ff ? irr_pkg::WALK_W'(irr_pkg::V6_DEPTH - 1) :
                               irr_pkg::WALK_W'(irr_pkg::V4_DEPTH - 1);

   always_comb begin
      res_acc = '0;
      if (look_ff) begin
         res_acc = fam_ff ? v6_acc[irr_pkg::V6_DEPTH - 1] : v4_acc[irr_pkg::V4_DEPTH - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         walk_ff       <= '0;
         look_ff       <= 1'b0;
         fam_ff        <= 1'b0;
         status_ff     <= irr_pkg::ST_OK;
         v4_cnt_ff     <= '0;
         v6_cnt_ff     <= '0;
         bl_cnt_ff     <= '0;
         ex_cnt_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= irr_pkg::ST_OK;
         rsp_acc_ff    <= '0;
         rsp_v4_ff     <= '0;
         rsp_v6_ff     <= '0;
         rsp_bl_ff     <= '0;
         rsp_ex_ff     <= '0;
      end else begin
         if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  look_ff   <= (req_bus.command == irr_pkg::CMD_LOOKUP);
                  fam_ff    <= req_bus.family;
                  status_ff <= status_in;
                  walk_ff   <= '0;
                  if (req_bus.command == irr_pkg::CMD_CLEAR) begin
                     v4_cnt_ff <= '0;
                     v6_cnt_ff <= '0;
                     bl_cnt_ff <= '0;
                     ex_cnt_ff <= '0;
                  end
                  if (ins_ok) begin
                     if (req_bus.family) begin
                        v6_cnt_ff <= v6_cnt_ff + 9'd1;
                     end else begin
                        v4_cnt_ff <= v4_cnt_ff + 11'd1;
                     end
                     if (req_bus.source_id) begin
                        ex_cnt_ff <= ex_cnt_ff + 11'd1;
                     end else begin
                        bl_cnt_ff <= bl_cnt_ff + 11'd1;
                     end
                  end
                  state_ff <= (req_bus.command == irr_pkg::CMD_LOOKUP) ? S_WALK : S_DONE;
               end
            end
            S_WALK: begin
               walk_ff <= walk_ff + irr_pkg::WALK_W'(1);
               if (walk_ff == walk_last) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_acc_ff    <= res_acc;
                  rsp_v4_ff     <= v4_cnt_ff;
                  rsp_v6_ff     <= v6_cnt_ff;
                  rsp_bl_ff     <= bl_cnt_ff;
                  rsp_ex_ff     <= ex_cnt_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.status            = rsp_status_ff;
   assign rsp_bus.hit               = rsp_acc_ff.hit;
   assign rsp_bus.hit_source        = rsp_acc_ff.src;
   assign rsp_bus.hit_label         = rsp_acc_ff.lab;
   assign rsp_bus.v4_entries        = rsp_v4_ff;
   assign rsp_bus.v6_entries        = rsp_v6_ff;
   assign rsp_bus.blocklist_entries = rsp_bl_ff;
   assign rsp_bus.exitlist_entries  = rsp_ex_ff;

endmodule

// ===== rtl/core/irr_v4_cell.sv =====
`timescale 1ns / 1ps
// One IPv4 table slot: holds an entry, shifts on sorted insert, and passes
// the lookup result chain on to its neighbor. Uses irr_pkg.
module irr_v4_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  irr_pkg::v4_ctl_type  ctl,
   input  irr_pkg::v4_entry_type prev_entry,
   input  logic                 prev_gt,
   input  logic                 next_gt,
   input  irr_pkg::acc_type     prev_acc,
   output irr_pkg::v4_entry_type entry,
   output logic                 gt,
   output irr_pkg::acc_type     acc
);

   logic                  valid_ff;
   irr_pkg::v4_entry_type data_ff;
   irr_pkg::v4_entry_type entry_in;
   irr_pkg::v4_entry_type cur;
   logic                  hit_ff;
   logic                  hit_in;
   irr_pkg::acc_type      acc_ff;
   irr_pkg::acc_type      acc_in;
   irr_pkg::acc_type      own;

   always_comb begin
      cur       = data_ff;
      cur.valid = valid_ff;
   end

   // empty slots sort after everything
   assign gt = !valid_ff || (data_ff.start > ctl.key);

   always_comb begin
      entry_in = cur;
      if (ctl.clr) begin
         entry_in.valid = 1'b0;
      end else if (ctl.ins && gt) begin
         if (prev_gt) begin
            entry_in = prev_entry;
         end else begin
            entry_in.valid = 1'b1;
            entry_in.start = ctl.key;
            entry_in.stop  = ctl.stop;
            entry_in.src   = ctl.src;
            entry_in.lab   = ctl.lab;
         end
      end
   end

   assign hit_in = (!gt && next_gt && (data_ff.stop >= ctl.key));

   always_comb begin
      own = '0;
      if (hit_ff) begin
         own.hit = 1'b1;
         own.src = data_ff.src;
         own.lab = data_ff.lab;
      end
      acc_in = acc_ff;
      if (ctl.look) begin
         acc_in = '0;
      end else if (ctl.walk) begin
         acc_in = prev_acc | own;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= entry_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= entry_in;
      acc_ff  <= acc_in;
      if (ctl.look) begin
         hit_ff <= hit_in;
      end
   end

   assign entry = cur;
   assign acc   = acc_ff;

endmodule

// ===== rtl/core/irr_v6_cell.sv =====
`timescale 1ns / 1ps
// One IPv6 table slot: holds an entry, shifts on sorted insert, and passes
// the lookup result chain on to its neighbor. Uses irr_pkg.
module irr_v6_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  irr_pkg::v6_ctl_type  ctl,
   input  irr_pkg::v6_entry_type prev_entry,
   input  logic                 prev_gt,
   input  logic                 next_gt,
   input  irr_pkg::acc_type     prev_acc,
   output irr_pkg::v6_entry_type entry,
   output logic                 gt,
   output irr_pkg::acc_type     acc
);

   logic                  valid_ff;
   irr_pkg::v6_entry_type data_ff;
   irr_pkg::v6_entry_type entry_in;
   irr_pkg::v6_entry_type cur;
   logic                  hit_ff;
   logic                  hit_in;
   irr_pkg::acc_type      acc_ff;
   irr_pkg::acc_type      acc_in;
   irr_pkg::acc_type      own;

   always_comb begin
      cur       = data_ff;
      cur.valid = valid_ff;
   end

   assign gt = !valid_ff || (data_ff.start > ctl.key);

   always_comb begin
      entry_in = cur;
      if (ctl.clr) begin
         entry_in.valid = 1'b0;
      end else if (ctl.ins && gt) begin
         if (prev_gt) begin
            entry_in = prev_entry;
         end else begin
            entry_in.valid = 1'b1;
            entry_in.start = ctl.key;
            entry_in.stop  = ctl.stop;
            entry_in.src   = ctl.src;
            entry_in.lab   = ctl.lab;
         end
      end
   end

   assign hit_in = (!gt && next_gt && (data_ff.stop >= ctl.key));

   always_comb begin
      own = '0;
      if (hit_ff) begin
         own.hit = 1'b1;
         own.src = data_ff.src;
         own.lab = data_ff.lab;
      end
      acc_in = acc_ff;
      if (ctl.look) begin
         acc_in = '0;
      end else if (ctl.walk) begin
         acc_in = prev_acc | own;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= entry_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= entry_in;
      acc_ff  <= acc_in;
      if (ctl.look) begin
         hit_ff <= hit_in;
      end
   end

   assign entry = cur;
   assign acc   = acc_ff;

endmodule

// ===== rtl/core/irr_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the IP range reputation table, bound to the top.
// Uses irr_pkg and the top level's channel signals.
module irr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic        rsp_hit,
   input logic        rsp_hit_source,
   input logic [7:0]  rsp_hit_label,
   input logic [10:0] rsp_v4_entries,
   input logic [8:0]  rsp_v6_entries
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_hit)
                                  && $stable(rsp_hit_label) && $stable(rsp_v4_entries)
                                  && $stable(rsp_v6_entries))
      else $error("response changed while stalled");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> !rsp_hit_source && (rsp_hit_label == 8'd0))
      else $error("miss carries source or label");

   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> (rsp_status == irr_pkg::ST_OK))
      else $error("hit with nonzero status");

   a_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_v4_entries) <= 32'(irr_pkg::V4_DEPTH))
                    && (32'(rsp_v6_entries) <= 32'(irr_pkg::V6_DEPTH)))
      else $error("entry count above table depth");

endmodule

bind ip_range_reputation_table irr_checker u_irr_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_status     (rsp_bus.status),
   .rsp_hit        (rsp_bus.hit),
   .rsp_hit_source (rsp_bus.hit_source),
   .rsp_hit_label  (rsp_bus.hit_label),
   .rsp_v4_entries (rsp_bus.v4_entries),
   .rsp_v6_entries (rsp_bus.v6_entries)
);

// ===== sim/tb_ip_range_reputation_table.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ip_range_reputation_table: directed, table-fill and
// random request streams checked against a sorted-range predictor.
// Depends on irr_pkg, irr_if and the block's RTL.
module tb_ip_range_reputation_table;

   localparam logic [1:0] CMD_RESERVED = 2'd3;
   localparam int IDLE_LIMIT = 5000;
   localparam int HOT_SPOTS  = 6;

   typedef struct packed {
      logic [1:0]  command;
      logic        family;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic [63:0] end_hi;
      logic [63:0] end_lo;
      logic        source_id;
      logic [7:0]  label_id;
   } request_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        hit;
      logic        hit_source;
      logic [7:0]  hit_label;
      logic [10:0] v4_entries;
      logic [8:0]  v6_entries;
      logic [10:0] blocklist_entries;
      logic [10:0] exitlist_entries;
   } response_type;

   typedef struct packed {
      logic [127:0] start;
      logic [127:0] stop;
      logic         src;
      logic [7:0]   lab;
   } range_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   irr_req_if req_bus ();
   irr_rsp_if rsp_bus ();

   ip_range_reputation_table DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   range_type    v4_ranges[$];
   range_type    v6_ranges[$];
   int           blocklist_total;
   int           exitlist_total;
   response_type pending_responses[$];
   int           mismatches;
   int           idle_cycles;
   bit           steady_flow;
   logic [63:0]  hot_hi[HOT_SPOTS];
   logic [63:0]  hot_lo[HOT_SPOTS];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int count_at_or_below(input logic fam, input logic [127:0] key);
      int n;
      n = 0;
      if (fam) begin
         while (n < v6_ranges.size() && v6_ranges[n].start <= key) n++;
      end else begin
         while (n < v4_ranges.size() && v4_ranges[n].start <= key) n++;
      end
      return n;
   endfunction

   function automatic response_type predict_reputation(input request_type rq);
      response_type rsp;
      range_type    r;
      logic [127:0] key;
      logic [127:0] last;
      int           p;
      rsp = '0;
      if (rq.family) begin
         key  = {rq.addr_hi, rq.addr_lo};
         last = {rq.end_hi, rq.end_lo};
      end else begin
         key  = {96'b0, rq.addr_lo[31:0]};
         last = {96'b0, rq.end_lo[31:0]};
      end
      r.start = key;
      r.stop  = last;
      r.src   = rq.source_id;
      r.lab   = (32'(rq.label_id) >= 32'(irr_pkg::LABEL_COUNT)) ?
                8'(irr_pkg::LABEL_COUNT - 1) : rq.label_id;
      case (rq.command)
         irr_pkg::CMD_INSERT: begin
            if (last < key) begin
               rsp.status = irr_pkg::ST_REVERSED;
            end else if (rq.family ? (v6_ranges.size() >= irr_pkg::V6_DEPTH)
                                   : (v4_ranges.size() >= irr_pkg::V4_DEPTH)) begin
               rsp.status = irr_pkg::ST_FULL;
            end else begin
               p = count_at_or_below(rq.family, key);
               if (rq.family) v6_ranges.insert(p, r);
               else v4_ranges.insert(p, r);
               if (r.src) exitlist_total++;
               else blocklist_total++;
            end
         end
         irr_pkg::CMD_LOOKUP: begin
            p = count_at_or_below(rq.family, key);
            if (p > 0) begin
               if (rq.family) r = v6_ranges[p - 1];
               else r = v4_ranges[p - 1];
               if (r.stop >= key) begin
                  rsp.hit        = 1'b1;
                  rsp.hit_source = r.src;
                  rsp.hit_label  = r.lab;
               end
            end
         end
         irr_pkg::CMD_CLEAR: begin
            v4_ranges.delete();
            v6_ranges.delete();
            blocklist_total = 0;
            exitlist_total  = 0;
         end
         default: ;
      endcase
      rsp.v4_entries        = 11'(v4_ranges.size());
      rsp.v6_entries        = 9'(v6_ranges.size());
      rsp.blocklist_entries = 11'(blocklist_total);
      rsp.exitlist_entries  = 11'(exitlist_total);
      return rsp;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   // IPv4 requests carry random junk in the bits the block must ignore
   function automatic request_type make_request(input logic [1:0] cmd, input logic fam,
                                                input logic [127:0] first,
                                                input logic [127:0] last,
                                                input logic src, input logic [7:0] lab);
      request_type rq;
      rq.command   = cmd;
      rq.family    = fam;
      rq.source_id = src;
      rq.label_id  = lab;
      if (fam) begin
         {rq.addr_hi, rq.addr_lo} = first;
         {rq.end_hi, rq.end_lo}   = last;
      end else begin
         rq.addr_hi = {$urandom, $urandom};
         rq.addr_lo = {$urandom, first[31:0]};
         rq.end_hi  = {$urandom, $urandom};
         rq.end_lo  = {$urandom, last[31:0]};
      end
      return rq;
   endfunction

   function automatic logic [127:0] pick_address(input logic fam);
      logic [127:0] a;
      int           h;
      if ($urandom_range(0, 9) < 7) begin
         h = $urandom_range(0, HOT_SPOTS - 1);
         a = {hot_hi[h], hot_lo[h] + 64'($urandom_range(0, 4095))};
      end else begin
         a = {$urandom, $urandom, $urandom, $urandom};
      end
      if (!fam) a = {96'b0, a[31:0]};
      return a;
   endfunction

   function automatic void pick_range(input logic fam, output logic [127:0] first,
                                      output logic [127:0] last);
      int sel;
      first = pick_address(fam);
      sel   = $urandom_range(0, 11);
      if (sel == 0) last = first;
      else if (sel == 1) last = first - 128'($urandom_range(1, 300));
      else if (sel == 2) last = {$urandom, $urandom, $urandom, $urandom};
      else last = first + 128'($urandom_range(1, 1500));
      if (!fam) last = {96'b0, last[31:0]};
   endfunction

   // probe edges and interiors of stored ranges most of the time
   function automatic logic [127:0] pick_probe(input logic fam);
      range_type    r;
      logic [127:0] a;
      int           n;
      n = fam ? v6_ranges.size() : v4_ranges.size();
      if (n == 0 || $urandom_range(0, 3) == 0) return pick_address(fam);
      if (fam) r = v6_ranges[$urandom_range(0, n - 1)];
      else r = v4_ranges[$urandom_range(0, n - 1)];
      case ($urandom_range(0, 4))
         0: a = r.start;
         1: a = r.stop;
         2: a = r.start - 1;
         3: a = r.stop + 1;
         default: a = r.start + 128'($urandom_range(0, 600));
      endcase
      if (!fam) a = {96'b0, a[31:0]};
      return a;
   endfunction

   task automatic send_request(input request_type rq);
      if (!steady_flow && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.command   <= rq.command;
      req_bus.family    <= rq.family;
      req_bus.addr_hi   <= rq.addr_hi;
      req_bus.addr_lo   <= rq.addr_lo;
      req_bus.end_hi    <= rq.end_hi;
      req_bus.end_lo    <= rq.end_lo;
      req_bus.source_id <= rq.source_id;
      req_bus.label_id  <= rq.label_id;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_responses.push_back(predict_reputation(rq));
   endtask

   task automatic send_range(input logic [1:0] cmd, input logic fam, input logic [127:0] first,
                             input logic [127:0] last, input logic src, input logic [7:0] lab);
      send_request(make_request(cmd, fam, first, last, src, lab));
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed_cases();
      request_type rq;
      send_range(irr_pkg::CMD_LOOKUP, 1'b0, 128'd0, '1, 1'b1, 8'hFF);
      send_range(irr_pkg::CMD_LOOKUP, 1'b1, '1, '1, 1'b0, 8'h00);
      send_range(irr_pkg::CMD_INSERT, 1'b0, 128'd0, 128'd0, 1'b0, 8'd0);
      rq = make_request(irr_pkg::CMD_INSERT, 1'b0, 128'hFFFF_FFFF, 128'hFFFF_FFFF, 1'b1,
                        8'hFF);
      rq.addr_hi = '1;
      rq.end_hi  = '1;
      rq.addr_lo[63:32] = '1;
      rq.end_lo[63:32]  = '1;
      send_request(rq);
      send_range(irr_pkg::CMD_INSERT, 1'b0, 128'd10, 128'd9, 1'b0, 8'd1);
      send_range(irr_pkg::CMD_INSERT, 1'b0, 128'd100, 128'd200, 1'b1, 8'd7);
      // equal start goes after the existing entry
      send_range(irr_pkg::CMD_INSERT, 1'b0, 128'd100, 128'd150, 1'b0, 8'd8);
      send_range(irr_pkg::CMD_LOOKUP, 1'b0, 128'd120, '0, 1'b0, 8'd0);
      send_range(irr_pkg::CMD_LOOKUP, 1'b0, 128'd175, '0, 1'b0, 8'd0);
      send_range(irr_pkg::CMD_LOOKUP, 1'b0, 128'd0, '0, 1'b0, 8'd0);
      send_range(irr_pkg::CMD_LOOKUP, 1'b0, 128'hFFFF_FFFF, '0, 1'b0, 8'd0);
      send_range(irr_pkg::CMD_LOOKUP, 1'b0, 128'd50, '0, 1'b0, 8'd0);
      send_range(irr_pkg::CMD_INSERT, 1'b1, 128'd0, '1, 1'b1, 8'd3);
      send_range(irr_pkg::CMD_INSERT, 1'b1, {64'd1, 64'd0}, {64'd0, 64'hFF}, 1'b0, 8'd4);
      send_range(irr_pkg::CMD_INSERT, 1'b1, {64'd1, 64'd0}, {64'd1, 64'hFF}, 1'b0, 8'd200);
      send_range(irr_pkg::CMD_LOOKUP, 1'b1, {64'd1, 64'h80}, '0, 1'b0, 8'd0);
      send_range(irr_pkg::CMD_LOOKUP, 1'b1, {64'd1, 64'h100}, '0, 1'b0, 8'd0);
      send_range(irr_pkg::CMD_LOOKUP, 1'b1, {64'd0, 64'd5}, '0, 1'b0, 8'd0);
      send_range(irr_pkg::CMD_LOOKUP, 1'b1, '1, '0, 1'b0, 8'd0);
      send_range(CMD_RESERVED, 1'b1, '1, '1, 1'b1, 8'hFF);
      send_range(irr_pkg::CMD_CLEAR, 1'b0, '0, '0, 1'b0, 8'd0);
      send_range(irr_pkg::CMD_LOOKUP, 1'b0, 128'd100, '0, 1'b0, 8'd0);
   endtask

   // fill the IPv6 table, then overflow; a reversed range on a full table reports reversed
   task automatic test_table_full();
      logic [127:0] first;
      logic [127:0] last;
      while (v6_ranges.size() < irr_pkg::V6_DEPTH) begin
         pick_range(1'b1, first, last);
         send_range(irr_pkg::CMD_INSERT, 1'b1, first, last, 1'($urandom), 8'($urandom));
      end
      send_range(irr_pkg::CMD_INSERT, 1'b1, 128'd5, 128'd5, 1'b1, 8'd9);
      send_range(irr_pkg::CMD_INSERT, 1'b1, 128'd6, 128'd5, 1'b0, 8'd9);
      send_range(irr_pkg::CMD_LOOKUP, 1'b1, pick_probe(1'b1), '0, 1'b0, 8'd0);
      send_range(irr_pkg::CMD_LOOKUP, 1'b0, pick_probe(1'b0), '0, 1'b0, 8'd0);
      send_range(irr_pkg::CMD_CLEAR, 1'b1, '1, '1, 1'b1, 8'hFF);
   endtask

   task automatic test_random_traffic(input int n_items);
      logic [127:0] first;
      logic [127:0] last;
      logic         fam;
      int           sent;
      int           pick;
      sent = 0;
      while (sent < n_items) begin
         if (sent >= n_items - 60) steady_flow = 1'b1;
         fam  = 1'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 48) begin
            pick_range(fam, first, last);
            send_range(irr_pkg::CMD_INSERT, fam, first, last, 1'($urandom), 8'($urandom));
            sent++;
         end else if (pick < 95) begin
            send_range(irr_pkg::CMD_LOOKUP, fam, pick_probe(fam),
                       {$urandom, $urandom, $urandom, $urandom},
                       1'($urandom), 8'($urandom));
            sent++;
         end else if (pick < 97) begin
            send_range(irr_pkg::CMD_CLEAR, fam, pick_address(fam), pick_address(fam),
                       1'($urandom), 8'($urandom));
            sent++;
         end else begin
            send_range(CMD_RESERVED, fam, pick_address(fam), pick_address(fam),
                       1'($urandom), 8'($urandom));
         end
      end
   endtask

   // ---------------------------------------------------------------- response side

   initial begin
      int hold;
      hold = 0;
      rsp_bus.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
         end else if (!steady_flow && $urandom_range(0, 6) == 0) begin
            hold = $urandom_range(0, 2);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      response_type got;
      response_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.status            = rsp_bus.status;
         got.hit               = rsp_bus.hit;
         got.hit_source        = rsp_bus.hit_source;
         got.hit_label         = rsp_bus.hit_label;
         got.v4_entries        = rsp_bus.v4_entries;
         got.v6_entries        = rsp_bus.v6_entries;
         got.blocklist_entries = rsp_bus.blocklist_entries;
         got.exitlist_entries  = rsp_bus.exitlist_entries;
         if (pending_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response with nothing outstanding: status=%0d hit=%0d",
                        $realtime, got.status, got.hit);
         end else begin
            want = pending_responses.pop_front();
            if (got.status !== want.status || got.hit !== want.hit ||
                got.hit_source !== want.hit_source || got.hit_label !== want.hit_label ||
                got.v4_entries !== want.v4_entries || got.v6_entries !== want.v6_entries ||
                got.blocklist_entries !== want.blocklist_entries ||
                got.exitlist_entries !== want.exitlist_entries) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"%0t: mismatch\n  expected status=%0d hit=%0d src=%0d label=%0d ",
                            "v4=%0d v6=%0d block=%0d exit=%0d\n  actual   status=%0d ",
                            "hit=%0d src=%0d label=%0d v4=%0d v6=%0d block=%0d exit=%0d"},
                           $realtime, want.status, want.hit, want.hit_source, want.hit_label,
                           want.v4_entries, want.v6_entries, want.blocklist_entries,
                           want.exitlist_entries, got.status, got.hit, got.hit_source,
                           got.hit_label, got.v4_entries, got.v6_entries,
                           got.blocklist_entries, got.exitlist_entries);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("ip_range_reputation_table regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      int h;
      mismatches      = 0;
      idle_cycles     = 0;
      steady_flow     = 1'b0;
      blocklist_total = 0;
      exitlist_total  = 0;
      hot_hi[0] = '0;
      hot_lo[0] = '0;
      hot_hi[1] = '1;
      hot_lo[1] = 64'hFFFF_FFFF_FFFF_F000;
      for (h = 2; h < HOT_SPOTS; h++) begin
         hot_hi[h] = {$urandom, $urandom};
         hot_lo[h] = {$urandom, $urandom};
      end
      req_bus.valid     <= 1'b0;
      req_bus.command   <= irr_pkg::CMD_INSERT;
      req_bus.family    <= 1'b0;
      req_bus.addr_hi   <= '0;
      req_bus.addr_lo   <= '0;
      req_bus.end_hi    <= '0;
      req_bus.end_lo    <= '0;
      req_bus.source_id <= 1'b0;
      req_bus.label_id  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_table_full();
      test_random_traffic(150);
      req_bus.valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("ip_range_reputation_table regression: pass");
      end else begin
         $display("ip_range_reputation_table regression: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/irr_pkg.sv
rtl/core/irr_if.sv
rtl/core/irr_v4_cell.sv
rtl/core/irr_v6_cell.sv
rtl/core/ip_range_reputation_table.sv
rtl/core/irr_checker.sv
sim/tb_ip_range_reputation_table.sv
